[hdl/spt_pkg.sv]
// spt_pkg: codes, fixed field widths and the command/status structs
// shared by the sorted priority table controller, datapath and top level.
// No dependencies.
package spt_pkg;

    localparam int RANK_W      = 6;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch the input word, index starts at the fill count
        logic rd_rank;   // read the entry at the requested rank
        logic rd_prev;   // read the entry just below the index
        logic place;     // write the new entry at the index
        logic shift;     // move the entry read up to the index, step index down
        logic finish;    // commit counts and load the result register
    } spt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            rank_ok;
        logic            idx_zero;
        logic            key_le;
        logic            out_free;
    } spt_sts_t;

endpackage

[hdl/spt_ctrl.sv]
// spt_ctrl: sequencer for one word at a time: dispatch, insertion walk,
// rank read and result hand-off. Depends on spt_pkg.
module spt_ctrl
    import spt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  spt_sts_t sts,
    output spt_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_TEST,
        S_INS_CMP,
        S_RD_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.op)
                    OP_INSERT:
                        state_next = sts.full ? S_FINISH : S_INS_TEST;
                    OP_READ:
                    begin
                        if (sts.rank_ok)
                        begin
                            cmd.rd_rank = 1'b1;
                            state_next  = S_RD_WAIT;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    default:
                        state_next = S_FINISH;
                endcase
            end
            S_INS_TEST:
            begin
                // bottom reached: the new entry goes to rank 0
                if (sts.idx_zero)
                begin
                    cmd.place  = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                // equal keys stay below the new entry, keeping arrival order
                if (sts.key_le)
                begin
                    cmd.place  = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.shift  = 1'b1;
                    state_next = S_INS_TEST;
                end
            end
            S_RD_WAIT:
                state_next = S_FINISH;
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/spt_datapath.sv]
// spt_datapath: entry memory, input word latch, walk index, fill count,
// batch error flag and the result register. Depends on spt_pkg.
module spt_datapath
    import spt_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int KEY_WIDTH   = 16,
    parameter int IDENT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  spt_cmd_t               cmd,
    output spt_sts_t               sts,
    input  logic [OP_W-1:0]        op,
    input  logic [KEY_WIDTH-1:0]   entry_health,
    input  logic [IDENT_WIDTH-1:0] entry_ident,
    input  logic [RANK_W-1:0]      rank,
    input  logic                   batch_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_W-1:0]    status,
    output logic [KEY_WIDTH-1:0]   out_health,
    output logic [IDENT_WIDTH-1:0] out_ident,
    output logic [COUNT_OUT_W-1:0] entry_count,
    output logic                   batch_failed
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;
    localparam int EW   = KEY_WIDTH + IDENT_WIDTH;
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    logic [EW-1:0] mem [CAPACITY];

    logic [OP_W-1:0]        op_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [IDENT_WIDTH-1:0] ident_reg;
    logic [RANK_W-1:0]      rank_reg;
    logic                   last_reg;
    logic [CW-1:0]          idx_reg;
    logic [CW-1:0]          idx_next;
    logic [EW-1:0]          rd_reg;

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   berr_reg;
    logic                   berr_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [STATUS_W-1:0]    out_status_next;
    logic [KEY_WIDTH-1:0]   out_health_reg;
    logic [KEY_WIDTH-1:0]   out_health_next;
    logic [IDENT_WIDTH-1:0] out_ident_reg;
    logic [IDENT_WIDTH-1:0] out_ident_next;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic [COUNT_OUT_W-1:0] out_count_next;
    logic                   out_bf_reg;
    logic                   out_bf_next;

    logic [CMPW-1:0]        rank_ext;
    logic [CMPW-1:0]        count_ext;
    logic [CW-1:0]          idx_dec;
    logic [AW-1:0]          rd_addr;
    logic                   rd_en;
    logic [AW-1:0]          wr_addr;
    logic [EW-1:0]          wr_data;
    logic                   wr_en;
    logic                   full;
    logic                   rank_ok;
    logic                   berr_eff;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [CW+COUNT_OUT_W-1:0] count_wide;

    assign rank_ext  = CMPW'(rank_reg);
    assign count_ext = CMPW'(count_reg);
    assign rank_ok   = rank_ext < count_ext;
    assign full      = count_reg >= CAP_COUNT;
    assign idx_dec   = idx_reg - CW'(1);
    assign rd_key    = rd_reg[EW-1:IDENT_WIDTH];

    assign sts.op       = op_reg;
    assign sts.full     = full;
    assign sts.rank_ok  = rank_ok;
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.key_le   = rd_key <= key_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    // memory port selection
    always_comb
    begin
        rd_en   = cmd.rd_rank | cmd.rd_prev;
        rd_addr = cmd.rd_rank ? rank_ext[AW-1:0] : idx_dec[AW-1:0];
        wr_en   = cmd.place | cmd.shift;
        wr_addr = idx_reg[AW-1:0];
        wr_data = cmd.shift ? rd_reg : {key_reg, ident_reg};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = count_reg;
        end
        else if (cmd.shift)
        begin
            idx_next = idx_dec;
        end
    end

    // result of the word just worked on
    always_comb
    begin
        count_next      = count_reg;
        berr_next       = berr_reg;
        berr_eff        = berr_reg | full;
        out_status_next = ST_OK;
        out_health_next = '0;
        out_ident_next  = '0;
        out_bf_next     = 1'b0;
        case (op_reg)
            OP_INSERT:
            begin
                if (full)
                begin
                    out_status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
                if (last_reg)
                begin
                    out_bf_next = berr_eff;
                    berr_next   = 1'b0;
                end
                else
                begin
                    berr_next = berr_eff;
                end
            end
            OP_READ:
            begin
                if (rank_ok)
                begin
                    out_health_next = rd_key;
                    out_ident_next  = rd_reg[IDENT_WIDTH-1:0];
                end
                else
                begin
                    out_status_next = ST_RANGE;
                end
            end
            OP_CLEAR:
                count_next = '0;
            default:
                count_next = count_reg;
        endcase
        count_wide     = {{COUNT_OUT_W{1'b0}}, count_next};
        out_count_next = count_wide[COUNT_OUT_W-1:0];
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            berr_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.finish)
            begin
                count_reg <= count_next;
                berr_reg  <= berr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            op_reg    <= op;
            key_reg   <= entry_health;
            ident_reg <= entry_ident;
            rank_reg  <= rank;
            last_reg  <= batch_last;
        end
        if (cmd.finish)
        begin
            out_status_reg <= out_status_next;
            out_health_reg <= out_health_next;
            out_ident_reg  <= out_ident_next;
            out_count_reg  <= out_count_next;
            out_bf_reg     <= out_bf_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_health   = out_health_reg;
    assign out_ident    = out_ident_reg;
    assign entry_count  = out_count_reg;
    assign batch_failed = out_bf_reg;

endmodule

[hdl/sorted_priority_table.sv]
// sorted_priority_table: top level joining the controller and the datapath.
// Depends on spt_pkg, spt_ctrl and spt_datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | op, entry_health, entry_ident, rank,
//          |                      | batch_last
//  out     | out_valid / out_ready| status, out_health, out_ident,
//          |                      | entry_count, batch_failed
//
// One word is worked on at a time. A read in range passes through dispatch,
// a memory read wait and finish; a clear, a spare op, a read out of range or
// an insert into a full table goes from dispatch straight to finish. An
// insert walks down from the top entry, one read and one compare per step,
// until the new entry lands at its rank or at rank 0. The next word is taken
// no earlier than the cycle after the result loads.
// Reset clears the fill count, the batch flag and the result valid; memory
// contents are not cleared. A stalled result holds in the output register;
// the next word is taken meanwhile and waits to be finished until it frees.
module sorted_priority_table
    import spt_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int KEY_WIDTH   = 16,
    parameter int IDENT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OP_W-1:0]        op,
    input  logic [KEY_WIDTH-1:0]   entry_health,
    input  logic [IDENT_WIDTH-1:0] entry_ident,
    input  logic [RANK_W-1:0]      rank,
    input  logic                   batch_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_W-1:0]    status,
    output logic [KEY_WIDTH-1:0]   out_health,
    output logic [IDENT_WIDTH-1:0] out_ident,
    output logic [COUNT_OUT_W-1:0] entry_count,
    output logic                   batch_failed
);

    spt_cmd_t cmd;
    spt_sts_t sts;

    spt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spt_datapath
    #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .IDENT_WIDTH (IDENT_WIDTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .op           (op),
        .entry_health (entry_health),
        .entry_ident  (entry_ident),
        .rank         (rank),
        .batch_last   (batch_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_health   (out_health),
        .out_ident    (out_ident),
        .entry_count  (entry_count),
        .batch_failed (batch_failed)
    );

endmodule
